>>> hw/rtl/circular_queue_unit_macros.svh
// assertion macros for the circular queue unit
// used by circular_queue_unit.sv, no other dependencies
`ifndef CIRCULAR_QUEUE_UNIT_MACROS_SVH
`define CIRCULAR_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CQU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular queue assertion failed");

// next-cycle implication, disabled while in reset
`define CQU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular queue assertion failed");

`endif

>>> hw/rtl/cqu_pkg.sv
// shared types, constants and helpers for the circular queue unit
// no dependencies
package cqu_pkg;

    // ring capacity and derived widths
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request kinds
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;
    localparam logic [1:0] KIND_DUMP = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // command queue between front and back
    localparam int CQ_SLOTS = 2;
    localparam int CQ_PTR_W = $clog2(CQ_SLOTS);
    localparam int CQ_CNT_W = $clog2(CQ_SLOTS + 1);

    // classified request
    typedef struct packed {
        logic [1:0]         op;
        logic               needs_read;
        logic signed [31:0] value;
    } t_cmd;

    // ring index advance with wrap at any depth
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

endpackage

>>> hw/rtl/cqu_front.sv
// front end: takes requests, classifies them and holds them in a small queue
// depends on cqu_pkg
module cqu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_cmd_valid,
    output cqu_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_take
);

    cqu_pkg::t_cmd                r_slot [cqu_pkg::CQ_SLOTS];
    logic [cqu_pkg::CQ_PTR_W-1:0] r_wr;
    logic [cqu_pkg::CQ_PTR_W-1:0] r_rd;
    logic [cqu_pkg::CQ_CNT_W-1:0] r_cnt;
    logic [cqu_pkg::CQ_CNT_W-1:0] n_cnt;
    cqu_pkg::t_cmd                cls;
    logic                         accept;

    // queue full stalls the input side
    assign o_in_stall  = (r_cnt == cqu_pkg::CQ_CNT_W'(cqu_pkg::CQ_SLOTS));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_slot[r_rd];

    // classify: every kind but push needs a storage read
    always_comb begin
        cls.op         = i_kind;
        cls.needs_read = (i_kind != cqu_pkg::KIND_PUSH);
        cls.value      = i_value;
    end

    // occupancy of the command queue
    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_cmd_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!accept && i_cmd_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_cmd_take) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr] <= cls;
        end
    end

endmodule

>>> hw/rtl/cqu_back.sv
// back end: ring storage, head/tail state, execution and result register
// depends on cqu_pkg
module cqu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  cqu_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_take,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_data,
    output logic                        o_last,
    output logic [cqu_pkg::CNT_W-1:0]   o_occupancy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic signed [31:0]        mem [cqu_pkg::DEPTH];
    logic signed [31:0]        r_rd_data;

    logic                      r_state, n_state;
    logic [cqu_pkg::IDX_W-1:0] r_head, n_head;
    logic [cqu_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [cqu_pkg::CNT_W-1:0] r_occ, n_occ;
    logic [cqu_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [cqu_pkg::CNT_W-1:0] r_left, n_left;
    logic [1:0]                r_op, n_op;

    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic signed [31:0]        r_data;
    logic                      r_last;

    logic                      out_ok;
    logic                      emit;
    logic [1:0]                e_status;
    logic signed [31:0]        e_data;
    logic                      e_last;
    logic                      wr_en;
    logic [cqu_pkg::IDX_W-1:0] rd_addr;

    assign out_ok      = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;
    assign o_occupancy = r_occ;

    // execution control
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_idx      = r_idx;
        n_left     = r_left;
        n_op       = r_op;
        o_cmd_take = 1'b0;
        emit       = 1'b0;
        e_status   = cqu_pkg::ST_OK;
        e_data     = '0;
        e_last     = 1'b1;
        wr_en      = 1'b0;
        rd_addr    = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_ok) begin
                    o_cmd_take = 1'b1;
                    if (!i_cmd.needs_read) begin
                        emit = 1'b1;
                        if (r_occ == cqu_pkg::CNT_W'(cqu_pkg::DEPTH)) begin
                            e_status = cqu_pkg::ST_FULL;
                        end else begin
                            wr_en  = 1'b1;
                            n_tail = cqu_pkg::next_idx(r_tail);
                            n_occ  = r_occ + 1'b1;
                            e_data = i_cmd.value;
                        end
                    end else if (r_occ == '0) begin
                        emit     = 1'b1;
                        e_status = cqu_pkg::ST_EMPTY;
                    end else begin
                        // head word is read this cycle, ready next cycle
                        n_state = S_RD;
                        n_op    = i_cmd.op;
                        n_idx   = r_head;
                        n_left  = r_occ;
                    end
                end
            end
            S_RD: begin
                rd_addr = r_idx;
                if (out_ok) begin
                    emit   = 1'b1;
                    e_data = r_rd_data;
                    e_last = (r_op != cqu_pkg::KIND_DUMP) ||
                             (r_left == cqu_pkg::CNT_W'(1));
                    if (r_op == cqu_pkg::KIND_POP) begin
                        n_head = cqu_pkg::next_idx(r_head);
                        n_occ  = r_occ - 1'b1;
                    end
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // dump continues with the following entry
                        n_idx   = cqu_pkg::next_idx(r_idx);
                        rd_addr = n_idx;
                        n_left  = r_left - 1'b1;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_op   <= n_op;
        if (emit) begin
            r_status <= e_status;
            r_data   <= e_data;
            r_last   <= e_last;
        end
    end

    // ring storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_cmd.value;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/circular_queue_unit.sv
// circular queue unit: ring-buffer fifo of signed 32-bit words
// push results come straight from the back end's result register; pop, peek and dump results
// also pass the registered read port of the ring storage; the back end takes no new request
// while a pop, peek or dump is reading, and a dump emits its entries one after another
// reset: synchronous active low, empties queue and command queue; storage is not cleared
// depends on cqu_pkg, cqu_front, cqu_back and circular_queue_unit_macros.svh
`include "circular_queue_unit_macros.svh"

module circular_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic               o_last
);

    logic                        cmd_valid;
    cqu_pkg::t_cmd               cmd;
    logic                        cmd_take;
    logic [cqu_pkg::CNT_W-1:0]   occupancy;
    logic                        occ_full;
    logic                        out_err;
    logic                        push_take;

    // request intake and classification
    cqu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // storage and execution
    cqu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_occupancy (occupancy)
    );

    // terms used by the checks below
    assign occ_full  = (occupancy == cqu_pkg::CNT_W'(cqu_pkg::DEPTH));
    assign out_err   = o_out_valid && (o_status != cqu_pkg::ST_OK);
    assign push_take = cmd_take && !cmd.needs_read;

    // occupancy never exceeds capacity
    `CQU_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, 1'b1, occupancy <= cqu_pkg::CNT_W'(cqu_pkg::DEPTH))
    // error results carry zero data and close their request
    `CQU_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, out_err, (o_data == '0) && o_last)
    // a stalled intake means the back end has a request waiting
    `CQU_ASSERT_NOW(a_stall_pending, i_clk, i_rst_n, o_in_stall, cmd_valid)
    // a refused push leaves the occupancy unchanged
    `CQU_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, push_take && occ_full, occ_full)

endmodule

>>> sim/circular_queue_unit_tb.sv
// self-checking testbench for the circular queue unit: push, pop, peek and dump requests
// checked against an in-bench ring model, with random idling on both handshakes
// depends on cqu_pkg and circular_queue_unit
module circular_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqu_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_COUNT = 450;
    localparam int SETTLE       = 24;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] value;
        bit                 drain;
    } request_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } result_t;

    // dut ports, all inputs known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_kind = KIND_PUSH;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic               o_last;

    circular_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    request_t           pending_requests[$];
    result_t            expected_results[$];

    // ring model state
    logic signed [31:0] ring_words[DEPTH];
    int                 ring_head = 0;
    int                 ring_tail = 0;
    int                 ring_count = 0;

    int                 owed_total = 0;
    int                 seen_total = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 send_gap = 0;
    int                 stall_left = 0;
    bit                 idle_en = 1'b0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int ring_next(input int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic void expect_result(input logic [1:0] status,
                                          input logic signed [31:0] data,
                                          input logic last);
        result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        expected_results.push_back(r);
        owed_total++;
    endfunction

    // ring model: apply one accepted request and queue the results it causes
    function automatic void queue_apply(input logic [1:0] kind,
                                        input logic signed [31:0] value);
        int idx;
        case (kind)
            KIND_PUSH: begin
                if (ring_count >= DEPTH) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else begin
                    ring_words[ring_tail] = value;
                    ring_tail = ring_next(ring_tail);
                    ring_count++;
                    expect_result(ST_OK, value, 1'b1);
                end
            end
            KIND_POP: begin
                if (ring_count == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    expect_result(ST_OK, ring_words[ring_head], 1'b1);
                    ring_head = ring_next(ring_head);
                    ring_count--;
                end
            end
            KIND_PEEK: begin
                if (ring_count == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    expect_result(ST_OK, ring_words[ring_head], 1'b1);
                end
            end
            default: begin
                if (ring_count == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    idx = ring_head;
                    for (int k = 0; k < ring_count; k++) begin
                        expect_result(ST_OK, ring_words[idx], (k + 1 == ring_count));
                        idx = ring_next(idx);
                    end
                end
            end
        endcase
    endfunction

    function automatic void note_error(input string msg);
        if (error_count < 10) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endfunction

    function automatic void add_request(input logic [1:0] kind,
                                        input logic signed [31:0] value,
                                        input bit drain);
        request_t q;
        q.kind  = kind;
        q.value = value;
        q.drain = drain;
        pending_requests.push_back(q);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // driver: presents pending requests, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                queue_apply(i_kind, i_value);
            end
            idle_en <= (pending_requests.size() > 40) &&
                       (((pending_requests.size() / 50) % 4) != 1);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_requests[0].drain && owed_total != seen_total) begin
                    // hold off until every outstanding result has come back
                    i_in_valid <= 1'b0;
                end else begin
                    i_kind     <= pending_requests[0].kind;
                    i_value    <= pending_requests[0].value;
                    i_in_valid <= 1'b1;
                    void'(pending_requests.pop_front());
                    if (idle_en && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 13);
                    end
                end
            end
        end
    end

    // monitor: checks accepted results and drives stall bursts
    always @(posedge i_clk) begin
        result_t r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_total <= seen_total + 1;
                if (expected_results.size() == 0) begin
                    note_error($sformatf("unexpected result status %0d data %0d last %0d",
                                         o_status, o_data, o_last));
                end else begin
                    r = expected_results.pop_front();
                    if (o_status !== r.status || o_data !== r.data || o_last !== r.last) begin
                        note_error($sformatf(
                            "expected status %0d data %0d last %0d, got %0d %0d %0d",
                            r.status, r.data, r.last, o_status, o_data, o_last));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (idle_en && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int push_bias;
        int roll;
        logic [1:0] kind;

        // empty queue cases
        add_request(KIND_PEEK, 32'sh1234_5678, 1'b0);
        add_request(KIND_POP, 32'sh7FFF_FFFF, 1'b0);
        add_request(KIND_DUMP, 32'sh8000_0000, 1'b0);
        // fill to capacity with extreme words
        add_request(KIND_PUSH, 32'sh8000_0000, 1'b0);
        add_request(KIND_PUSH, 32'sh7FFF_FFFF, 1'b0);
        add_request(KIND_PUSH, '0, 1'b0);
        add_request(KIND_PUSH, -32'sd1, 1'b0);
        add_request(KIND_PUSH, 32'sd1, 1'b0);
        add_request(KIND_PUSH, 32'shAAAA_AAAA, 1'b0);
        add_request(KIND_PUSH, 32'sh5555_5555, 1'b0);
        add_request(KIND_PUSH, -32'sd2, 1'b0);
        // push refused when full, then peek and a full dump
        add_request(KIND_PUSH, 32'sh0F0F_0F0F, 1'b0);
        add_request(KIND_PEEK, '0, 1'b0);
        add_request(KIND_DUMP, '0, 1'b1);
        // pops and pushes that wrap the ring indices
        add_request(KIND_POP, '0, 1'b0);
        add_request(KIND_POP, '0, 1'b0);
        add_request(KIND_POP, '0, 1'b0);
        add_request(KIND_PUSH, 32'sh0000_FFFF, 1'b0);
        add_request(KIND_PUSH, 32'shFFFF_0000, 1'b0);
        add_request(KIND_PUSH, 32'sh3C3C_C3C3, 1'b0);
        add_request(KIND_DUMP, '0, 1'b0);

        // random part, push bias swings so the ring goes full and empty often
        push_bias = 50;
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i % 30 == 0) begin
                push_bias = $urandom_range(15, 85);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                kind = KIND_DUMP;
            end else if (roll < 18) begin
                kind = KIND_PEEK;
            end else if ($urandom_range(0, 99) < push_bias) begin
                kind = KIND_PUSH;
            end else begin
                kind = KIND_POP;
            end
            add_request(kind, pick_value(), (i % 150) == 75);
        end

        // reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests to go in and all results to come out
        while (pending_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        while (seen_total != owed_total) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cqu_pkg.sv
hw/rtl/cqu_front.sv
hw/rtl/cqu_back.sv
hw/rtl/circular_queue_unit.sv
sim/circular_queue_unit_tb.sv
